[src/pvdh_pkg.sv]
package pvdh_pkg;

  localparam int GRID_MAX  = 32;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W   = $clog2(GRID_MAX);
  localparam int SIDE_W  = $clog2(GRID_MAX + 1);
  localparam int DEPTH   = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SHIFT   = 2 * FRAC_BITS;

  localparam int COORD_W = 32;
  localparam int DENS_W  = 32;
  localparam int HALF_W  = 31;
  localparam int GSIDE_W = 6;
  localparam int WIDE_W  = COORD_W + 2;
  localparam int PROD_W  = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPOSIT_AMOUNT = 2'd3;

  localparam logic [HALF_W-1:0]  RST_HALF_EXTENT    = 31'd65536;
  localparam logic [GSIDE_W-1:0] RST_GRID_SIDE      = 6'd32;
  localparam logic [31:0]        RST_CELL_SCALE     = 32'd1048576;
  localparam logic [DENS_W-1:0]  RST_DEPOSIT_AMOUNT = 32'd65536;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_LOOKUP  = 1'b1;

  typedef struct packed {
    logic       load;
    logic       wrap;
    logic       range;
    logic       mul;
    logic       clamp;
    logic       addr1;
    logic       addr2;
    logic       read;
    logic       finish;
    logic       clear;
    logic [1:0] axis;
  } pvdh_cmd_t;

  typedef struct packed {
    logic in_box;
    logic clr_last;
    logic out_free;
  } pvdh_sts_t;

endpackage

[src/pvdh_if.sv]
interface pvdh_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [pvdh_pkg::COORD_W-1:0]  pos_x;
  logic signed [pvdh_pkg::COORD_W-1:0]  pos_y;
  logic signed [pvdh_pkg::COORD_W-1:0]  pos_z;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, pos_z, output ready);
endinterface

interface pvdh_out_if;
  logic                          valid;
  logic                          ready;
  logic [pvdh_pkg::DENS_W-1:0]   density_value;
  logic                          out_of_range;
  logic                          saturated;

  modport source (output valid, density_value, out_of_range, saturated, input ready);
  modport sink   (input valid, density_value, out_of_range, saturated, output ready);
endinterface

[src/pvdh_ctrl.sv]
module pvdh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pvdh_pkg::pvdh_sts_t sts,
  output pvdh_pkg::pvdh_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRAP  = 4'd2;
  localparam logic [3:0] S_RANGE = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_CLAMP = 4'd5;
  localparam logic [3:0] S_ADDR1 = 4'd6;
  localparam logic [3:0] S_ADDR2 = 4'd7;
  localparam logic [3:0] S_READ  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      axis_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        cmd.range = 1'b1;
        axis_nxt  = 2'd0;
        // drop straight to the result when any axis is outside the box
        state_nxt = sts.in_box ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = S_ADDR1;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_ADDR1: begin
        cmd.addr1 = 1'b1;
        state_nxt = S_ADDR2;
      end
      S_ADDR2: begin
        cmd.addr2 = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

[src/pvdh_dp.sv]
module pvdh_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pvdh_pkg::pvdh_cmd_t                  cmd,
  output pvdh_pkg::pvdh_sts_t                  sts,
  input  logic [pvdh_pkg::HALF_W-1:0]          half_extent,
  input  logic [pvdh_pkg::GSIDE_W-1:0]         grid_side,
  input  logic [31:0]                          cell_scale,
  input  logic [pvdh_pkg::DENS_W-1:0]          deposit_amount,
  input  logic                                 in_opcode,
  input  logic signed [pvdh_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [pvdh_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [pvdh_pkg::COORD_W-1:0]  in_pos_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pvdh_pkg::DENS_W-1:0]          out_density_value,
  output logic                                 out_out_of_range,
  output logic                                 out_saturated
);

  localparam int WIDE_W = pvdh_pkg::WIDE_W;
  localparam int ADDR_W = pvdh_pkg::ADDR_W;
  localparam int IDX_W  = pvdh_pkg::IDX_W;
  localparam int SIDE_W = pvdh_pkg::SIDE_W;
  localparam int DENS_W = pvdh_pkg::DENS_W;
  localparam int PROD_W = pvdh_pkg::PROD_W;

  logic [DENS_W-1:0] mem [pvdh_pkg::DEPTH];

  logic                                op_r;
  logic signed [pvdh_pkg::COORD_W-1:0] pos_r [3];
  logic signed [WIDE_W-1:0]            cw_r  [3];
  logic signed [WIDE_W-1:0]            cw_nxt [3];
  logic [31:0]                         off_r [3];
  logic                                ok_r;
  logic [PROD_W-1:0]                   prod_r;
  logic [IDX_W-1:0]                    idx_r [3];
  logic [ADDR_W-1:0]                   part_r;
  logic [ADDR_W-1:0]                   addr_r;
  logic [DENS_W-1:0]                   rd_data_r;
  logic [ADDR_W-1:0]                   clr_cnt_r;

  logic                                out_valid_r;
  logic [DENS_W-1:0]                   out_dens_r;
  logic                                out_oor_r;
  logic                                out_sat_r;

  logic signed [WIDE_W-1:0] he_s, neg_he_s, h2_s;
  logic [2:0]               axis_in;
  logic [SIDE_W-1:0]        side;
  logic [PROD_W-1:0]        shifted;
  logic [PROD_W-1:0]        side_m1;
  logic [PROD_W-1:0]        idx_sel;
  logic [DENS_W:0]          sum;
  logic [DENS_W-1:0]        dep_value;
  logic                     dep_sat;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_wa;
  logic [DENS_W-1:0]        mem_wd;

  assign he_s     = signed'({3'b000, half_extent});
  assign neg_he_s = -he_s;
  assign h2_s     = signed'({2'b00, half_extent, 1'b0});

  // grid side zero acts as one, above the store's side acts as the full side
  always_comb begin
    if (grid_side == '0) begin
      side = SIDE_W'(1);
    end else if (32'(grid_side) > pvdh_pkg::GRID_MAX) begin
      side = SIDE_W'(pvdh_pkg::GRID_MAX);
    end else begin
      side = SIDE_W'(grid_side);
    end
  end

  // one wrap per axis on deposits only
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cw_nxt[a] = {{2{pos_r[a][pvdh_pkg::COORD_W-1]}}, pos_r[a]};
      if (op_r == pvdh_pkg::OP_DEPOSIT) begin
        if (cw_nxt[a] < neg_he_s) begin
          cw_nxt[a] = cw_nxt[a] + h2_s;
        end else if (cw_nxt[a] > he_s) begin
          cw_nxt[a] = cw_nxt[a] - h2_s;
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_in[a] = (cw_r[a] >= neg_he_s) && (cw_r[a] <= he_s);
    end
  end

  assign shifted = prod_r >> pvdh_pkg::SHIFT;
  assign side_m1 = PROD_W'(side) - PROD_W'(1);
  assign idx_sel = (shifted > side_m1) ? side_m1 : shifted;

  assign sum       = {1'b0, rd_data_r} + {1'b0, deposit_amount};
  assign dep_sat   = sum[DENS_W];
  assign dep_value = dep_sat ? '1 : sum[DENS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
    end
    if (cmd.wrap) begin
      for (int a = 0; a < 3; a++) cw_r[a] <= cw_nxt[a];
    end
    if (cmd.range) begin
      ok_r <= &axis_in;
      for (int a = 0; a < 3; a++) off_r[a] <= 32'(cw_r[a] + he_s);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(off_r[cmd.axis]) * PROD_W'(cell_scale);
    end
    if (cmd.clamp) begin
      idx_r[cmd.axis] <= idx_sel[IDX_W-1:0];
    end
    if (cmd.addr1) begin
      part_r <= ADDR_W'(idx_r[1]) + ADDR_W'(side) * ADDR_W'(idx_r[2]);
    end
    if (cmd.addr2) begin
      addr_r <= ADDR_W'(idx_r[0]) + ADDR_W'(side) * part_r;
    end
  end

  assign mem_we = cmd.clear || (cmd.finish && ok_r && (op_r == pvdh_pkg::OP_DEPOSIT));
  assign mem_wa = cmd.clear ? clr_cnt_r : addr_r;
  assign mem_wd = cmd.clear ? '0 : dep_value;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.read) rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!ok_r) begin
        out_dens_r <= '0;
        out_oor_r  <= 1'b1;
        out_sat_r  <= 1'b0;
      end else if (op_r == pvdh_pkg::OP_LOOKUP) begin
        out_dens_r <= rd_data_r;
        out_oor_r  <= 1'b0;
        out_sat_r  <= 1'b0;
      end else begin
        out_dens_r <= dep_value;
        out_oor_r  <= 1'b0;
        out_sat_r  <= dep_sat;
      end
    end
  end

  assign sts.in_box   = &axis_in;
  assign sts.clr_last = (32'(clr_cnt_r) == pvdh_pkg::DEPTH - 1);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_density_value = out_dens_r;
  assign out_out_of_range  = out_oor_r;
  assign out_saturated     = out_sat_r;

endmodule

[src/periodic_voxel_density_histogram_top.sv]
// Periodic voxel density histogram. After reset the block clears its voxel store one
// entry per cycle and takes no beat on in_ch until that is done; configuration writes
// are taken throughout. It works on one item at a time: after WRAP and RANGE, a point
// inside the box steps through MUL and CLAMP per axis, then ADDR1, ADDR2 and READ; one
// outside goes straight to DONE, which holds while the output beat waits. One shared
// 32x32 multiplier scales the three axes in turn, and the voxel store has a single read
// and write port. The result sits in an output register, so the next item is taken
// while it waits on out_ch. Voxel index per axis is floor((coord + half_extent) *
// cell_scale) clamped to side - 1 (side is grid_side held to 1..32), with the layout
// x + y*side + z*side*side; deposits wrap each coordinate once and saturate the density.
module periodic_voxel_density_histogram_top (
  input  logic                                clk,
  input  logic                                rst_n,
  pvdh_in_if.sink                             in_ch,
  pvdh_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [pvdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pvdh_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [pvdh_pkg::HALF_W-1:0]  half_extent_r;
  logic [pvdh_pkg::GSIDE_W-1:0] grid_side_r;
  logic [31:0]                  cell_scale_r;
  logic [pvdh_pkg::DENS_W-1:0]  deposit_amount_r;

  pvdh_pkg::pvdh_cmd_t cmd;
  pvdh_pkg::pvdh_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_extent_r    <= pvdh_pkg::RST_HALF_EXTENT;
      grid_side_r      <= pvdh_pkg::RST_GRID_SIDE;
      cell_scale_r     <= pvdh_pkg::RST_CELL_SCALE;
      deposit_amount_r <= pvdh_pkg::RST_DEPOSIT_AMOUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvdh_pkg::REG_HALF_EXTENT:    half_extent_r    <= cfg_wdata[pvdh_pkg::HALF_W-1:0];
        pvdh_pkg::REG_GRID_SIDE:      grid_side_r      <= cfg_wdata[pvdh_pkg::GSIDE_W-1:0];
        pvdh_pkg::REG_CELL_SCALE:     cell_scale_r     <= cfg_wdata[31:0];
        pvdh_pkg::REG_DEPOSIT_AMOUNT: deposit_amount_r <= cfg_wdata[pvdh_pkg::DENS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pvdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pvdh_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .half_extent       (half_extent_r),
    .grid_side         (grid_side_r),
    .cell_scale        (cell_scale_r),
    .deposit_amount    (deposit_amount_r),
    .in_opcode         (in_ch.opcode),
    .in_pos_x          (in_ch.pos_x),
    .in_pos_y          (in_ch.pos_y),
    .in_pos_z          (in_ch.pos_z),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_density_value (out_ch.density_value),
    .out_out_of_range  (out_ch.out_of_range),
    .out_saturated     (out_ch.saturated)
  );

endmodule

[verif/tb_periodic_voxel_density_histogram_top.sv]
`timescale 1ns / 100ps

module tb_periodic_voxel_density_histogram_top;
  import pvdh_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              out_of_range;
    logic              saturated;
  } voxel_result_t;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE} rx_mode_t;

  localparam logic signed [COORD_W-1:0] ONE_Q = 32'sd65536;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pvdh_in_if  in_if ();
  pvdh_out_if out_if ();

  periodic_voxel_density_histogram_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the voxel store and registers
  logic [DENS_W-1:0]  density_mem [DEPTH];
  logic [HALF_W-1:0]  half_q;
  logic [GSIDE_W-1:0] side_q;
  logic [31:0]        scale_q;
  logic [DENS_W-1:0]  amount_q;

  voxel_result_t expected_q [$];
  point_t        deposit_hist [$];

  int err_count    = 0;
  int n_deposit    = 0;
  int n_lookup     = 0;
  int n_outside    = 0;
  int n_saturated  = 0;
  int n_reg_writes = 0;
  int burst_left   = 0;

  rx_mode_t rx_mode = RX_STREAM;
  int       rx_left = 0;

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    err_count++;
  endtask

  function automatic point_t point_at(logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y,
                                      logic signed [COORD_W-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic int axis_cell(longint c, int side);
    logic [63:0] off;
    logic [63:0] prod;
    longint      h;
    h    = longint'(half_q);
    off  = c + h;
    prod = (off * {32'd0, scale_q}) >> SHIFT;
    if (prod > side - 1) return side - 1;
    return int'(prod);
  endfunction

  // Work out the result of one accepted beat and update the shadow store
  function automatic void predict_density(logic op, point_t pt);
    longint                    h;
    longint                    c [3];
    logic signed [COORD_W-1:0] raw [3];
    logic                      in_box;
    int                        side;
    int                        addr;
    int                        a;
    logic [DENS_W:0]           sum;
    voxel_result_t             r;
    h      = longint'(half_q);
    raw[0] = pt.x;
    raw[1] = pt.y;
    raw[2] = pt.z;
    in_box = 1'b1;
    r      = '0;
    for (a = 0; a < 3; a++) begin
      c[a] = longint'(raw[a]);
      if (op == OP_DEPOSIT) begin
        if (c[a] < -h) c[a] += 2 * h;
        else if (c[a] > h) c[a] -= 2 * h;
      end
      if (c[a] < -h || c[a] > h) in_box = 1'b0;
    end
    if (!in_box) begin
      r.out_of_range = 1'b1;
      n_outside++;
    end else begin
      side = int'(side_q);
      if (side == 0) side = 1;
      if (side > GRID_MAX) side = GRID_MAX;
      addr = axis_cell(c[0], side) + axis_cell(c[1], side) * side
           + axis_cell(c[2], side) * side * side;
      if (addr > DEPTH - 1) addr = DEPTH - 1;
      if (op == OP_LOOKUP) begin
        r.density = density_mem[addr];
      end else begin
        sum = {1'b0, density_mem[addr]} + {1'b0, amount_q};
        if (sum[DENS_W]) begin
          r.density   = '1;
          r.saturated = 1'b1;
          n_saturated++;
        end else begin
          r.density = sum[DENS_W-1:0];
        end
        density_mem[addr] = r.density;
      end
    end
    if (op == OP_LOOKUP) n_lookup++;
    else n_deposit++;
    expected_q.push_back(r);
  endfunction

  function automatic logic signed [COORD_W-1:0] coord_near_box();
    longint h;
    longint v;
    int     jitter;
    h      = longint'(half_q);
    jitter = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = -h + longint'($urandom) % (2 * h + 1);
      5, 6: v = ($urandom_range(0, 1) ? h : -h) + jitter;
      // past the bound, where a deposit wraps back in (or lands just outside)
      7, 8: begin
        v = h + 1 + longint'($urandom) % (2 * h + 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = longint'(int'($urandom));
    endcase
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[COORD_W-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_HALF_EXTENT:    half_q   = data[HALF_W-1:0];
      REG_GRID_SIDE:      side_q   = data[GSIDE_W-1:0];
      REG_CELL_SCALE:     scale_q  = data;
      REG_DEPOSIT_AMOUNT: amount_q = data;
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Send one beat; the sender runs in bursts with random gaps in between
  task automatic send_item(input logic op, input point_t pt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_if.valid  = 1'b1;
    in_if.opcode = op;
    in_if.pos_x  = pt.x;
    in_if.pos_y  = pt.y;
    in_if.pos_z  = pt.z;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_density(op, pt);
    burst_left--;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe drain
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_STREAM: out_if.ready = 1'b1;
      RX_COIN:   out_if.ready = 1'($urandom_range(0, 1));
      default:   out_if.ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    voxel_result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with no item outstanding");
      end else begin
        want = expected_q.pop_front();
        if (out_if.density_value !== want.density)
          report_mismatch($sformatf("density_value %h, want %h",
                                    out_if.density_value, want.density));
        if (out_if.out_of_range !== want.out_of_range)
          report_mismatch($sformatf("out_of_range %b, want %b",
                                    out_if.out_of_range, want.out_of_range));
        if (out_if.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %b, want %b",
                                    out_if.saturated, want.saturated));
      end
    end
  end

  // Reset registers: box of +-1.0, 32 voxels per axis, deposit of 1.0
  task automatic test_box_edges();
    wait_idle();
    send_item(OP_DEPOSIT, point_at(32'sd0, 32'sd0, 32'sd0));
    send_item(OP_DEPOSIT, point_at(ONE_Q, ONE_Q, ONE_Q));
    send_item(OP_DEPOSIT, point_at(-ONE_Q, -ONE_Q, -ONE_Q));
    send_item(OP_DEPOSIT, point_at(ONE_Q + 1, 32'sd0, -ONE_Q - 1));
    send_item(OP_DEPOSIT, point_at(3 * ONE_Q + 1, 32'sd0, 32'sd0));
    send_item(OP_DEPOSIT, point_at(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0));
    send_item(OP_LOOKUP, point_at(32'sd0, 32'sd0, 32'sd0));
    send_item(OP_LOOKUP, point_at(ONE_Q, ONE_Q, ONE_Q));
    send_item(OP_LOOKUP, point_at(-ONE_Q, -ONE_Q, -ONE_Q));
    send_item(OP_LOOKUP, point_at(ONE_Q + 1, 32'sd0, 32'sd0));
    send_item(OP_LOOKUP, point_at(-ONE_Q + 1, 32'sd0, ONE_Q - 1));
    send_item(OP_LOOKUP, point_at(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_item(OP_DEPOSIT, point_at(32'sd0, 32'sd0, 32'sd0));
  endtask

  task automatic test_saturation();
    wait_idle();
    write_reg(REG_DEPOSIT_AMOUNT, 32'hFFFF_FFFF);
    send_item(OP_DEPOSIT, point_at(32'sd0, 32'sd0, 32'sd0));
    send_item(OP_DEPOSIT, point_at(32'sd0, 32'sd0, 32'sd0));
    wait_idle();
    write_reg(REG_DEPOSIT_AMOUNT, 32'd0);
    send_item(OP_DEPOSIT, point_at(-ONE_Q, -ONE_Q, -ONE_Q));
    send_item(OP_LOOKUP, point_at(32'sd0, 32'sd0, 32'sd0));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    // zero half extent: only the origin is inside
    write_reg(REG_HALF_EXTENT, 32'd0);
    write_reg(REG_DEPOSIT_AMOUNT, 32'd65536);
    send_item(OP_DEPOSIT, point_at(32'sd0, 32'sd0, 32'sd0));
    send_item(OP_DEPOSIT, point_at(32'sd1, 32'sd0, 32'sd0));
    send_item(OP_LOOKUP, point_at(32'sd0, 32'sd0, -32'sd1));
    wait_idle();
    // widest box, largest scale, side above the grid limit
    write_reg(REG_HALF_EXTENT, 32'h7FFF_FFFF);
    write_reg(REG_CELL_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_GRID_SIDE, 32'd63);
    send_item(OP_DEPOSIT, point_at(32'sh7FFF_FFFF, 32'sh8000_0001, 32'sd0));
    send_item(OP_DEPOSIT, point_at(32'sh8000_0000, 32'sd0, 32'sh7FFF_FFFF));
    send_item(OP_LOOKUP, point_at(32'sh8000_0000, 32'sd0, 32'sd0));
    wait_idle();
    // zero side and zero scale fold everything onto one voxel
    write_reg(REG_GRID_SIDE, 32'd0);
    write_reg(REG_CELL_SCALE, 32'd0);
    send_item(OP_DEPOSIT, point_at(32'sd12345, -32'sd777, ONE_Q));
    send_item(OP_LOOKUP, point_at(-32'sd5, 32'sd5, 32'sd0));
  endtask

  task automatic test_random_traffic();
    logic [30:0] h_new;
    logic [31:0] side_new;
    logic [31:0] scale_new;
    logic [31:0] amount_new;
    logic [63:0] nominal;
    int          s_use;
    int          ph;
    int          i;
    point_t      pt;
    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       h_new = 31'($urandom_range(1, 16));
        1, 2:    h_new = 31'($urandom_range(1 << 14, 1 << 20));
        3:       h_new = 31'($urandom_range(1 << 20, 1 << 28));
        4:       h_new = 31'($urandom);
        default: h_new = 31'h7FFF_FFFF;
      endcase
      case ($urandom_range(0, 3))
        0, 1:    side_new = $urandom_range(1, 4);
        2:       side_new = $urandom_range(5, 32);
        default: side_new = $urandom_range(0, 63);
      endcase
      s_use = side_new;
      if (s_use == 0) s_use = 1;
      if (s_use > GRID_MAX) s_use = GRID_MAX;
      // scale that maps the box onto the grid, at times overshot to hit the clamp
      if (h_new == 0) nominal = 64'($urandom);
      else nominal = (64'(s_use) << 31) / h_new;
      case ($urandom_range(0, 6))
        0:       nominal = nominal + nominal / 8 + 1;
        1:       nominal = 64'($urandom);
        default: ;
      endcase
      scale_new = (nominal > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nominal[31:0];
      case ($urandom_range(0, 7))
        0, 1, 2, 3, 4: amount_new = $urandom_range(1, 1 << 18);
        5, 6:          amount_new = $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
        default:       amount_new = $urandom;
      endcase
      write_reg(REG_HALF_EXTENT, {1'b0, h_new});
      write_reg(REG_GRID_SIDE, side_new);
      write_reg(REG_CELL_SCALE, scale_new);
      write_reg(REG_DEPOSIT_AMOUNT, amount_new);
      for (i = 0; i < 240; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            pt = point_at(coord_near_box(), coord_near_box(), coord_near_box());
            send_item(OP_DEPOSIT, pt);
            deposit_hist.push_back(pt);
            if (deposit_hist.size() > 64) void'(deposit_hist.pop_front());
          end
          5, 6, 7: begin
            // revisit a deposited point so lookups see nonzero density
            if (deposit_hist.size() != 0)
              pt = deposit_hist[$urandom_range(0, deposit_hist.size() - 1)];
            else
              pt = point_at(coord_near_box(), coord_near_box(), coord_near_box());
            send_item(OP_LOOKUP, pt);
          end
          default: begin
            pt = point_at(coord_near_box(), coord_near_box(), coord_near_box());
            send_item(OP_LOOKUP, pt);
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.opcode  = OP_DEPOSIT;
    in_if.pos_x   = '0;
    in_if.pos_y   = '0;
    in_if.pos_z   = '0;
    half_q        = RST_HALF_EXTENT;
    side_q        = RST_GRID_SIDE;
    scale_q       = RST_CELL_SCALE;
    amount_q      = RST_DEPOSIT_AMOUNT;
    foreach (density_mem[k]) density_mem[k] = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_box_edges();
    test_saturation();
    test_register_extremes();
    test_random_traffic();
    wait_idle();

    $display("Checked %0d deposits and %0d lookups across %0d register writes.",
             n_deposit, n_lookup, n_reg_writes);
    $display("Of those, %0d points fell outside the box and %0d deposits saturated.",
             n_outside, n_saturated);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
